// ----- hdl/percent_escape_decoder_core_assert.svh -----
// Assertion macros for the percent escape decoder.
`ifndef PERCENT_ESCAPE_DECODER_CORE_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PEDEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PEDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pedec_pkg.sv -----
`timescale 1ns / 1ps
package pedec_pkg;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_PERCENT      = 8'h25;
  localparam logic [7:0] CH_PLUS         = 8'h2B;
  localparam logic [7:0] CH_SPACE        = 8'h20;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  // One decoded request: up to three bytes, last flag on the final one.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b0;
    h.val   = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.val   = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.valid = 1'b1;
      h.val   = 4'(c[3:0] - 4'd1 + HEX_LETTER_BASE);
    end
    return h;
  endfunction

endpackage

// ----- hdl/pedec_front.sv -----
`timescale 1ns / 1ps
module pedec_front
  import pedec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  q_stat_t    q_stat,
  output logic       push,
  output req_t       push_req,
  output logic       idle
);

  typedef enum logic [1:0] {ST_IDLE, ST_PCT, ST_HEX} state_t;

  state_t     st_r, st_nxt;
  logic [7:0] held_r, held_nxt;
  logic       acc;
  hex_t       hb, hd;
  logic       pl_emit;
  logic [7:0] pl_byte;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign idle     = (st_r == ST_IDLE);

  always_comb begin
    hb       = hex_digit(in_byte);
    hd       = hex_digit(held_r);
    pl_emit  = !((in_byte == CH_PERCENT) && !in_last);
    pl_byte  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    push_req = '0;
    push_req.last = in_last;
    st_nxt   = st_r;
    held_nxt = held_r;
    unique case (st_r)
      ST_PCT: begin
        if (hb.valid) begin
          if (in_last) begin
            push_req.cnt      = 2'd2;
            push_req.bytes[0] = CH_PERCENT;
            push_req.bytes[1] = in_byte;
            st_nxt            = ST_IDLE;
          end else begin
            held_nxt = in_byte;
            st_nxt   = ST_HEX;
          end
        end else begin
          push_req.bytes[0] = CH_PERCENT;
          push_req.bytes[1] = pl_byte;
          push_req.cnt      = pl_emit ? 2'd2 : 2'd1;
          st_nxt            = pl_emit ? ST_IDLE : ST_PCT;
        end
      end
      ST_HEX: begin
        if (hb.valid) begin
          push_req.bytes[0] = {hd.val, hb.val};
          push_req.cnt      = 2'd1;
          st_nxt            = ST_IDLE;
        end else begin
          push_req.bytes[0] = CH_PERCENT;
          push_req.bytes[1] = held_r;
          push_req.bytes[2] = pl_byte;
          push_req.cnt      = pl_emit ? 2'd3 : 2'd2;
          st_nxt            = pl_emit ? ST_IDLE : ST_PCT;
        end
      end
      default: begin
        push_req.bytes[0] = pl_byte;
        push_req.cnt      = pl_emit ? 2'd1 : 2'd0;
        st_nxt            = pl_emit ? ST_IDLE : ST_PCT;
      end
    endcase
    push = acc && (push_req.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      held_r <= '0;
    end else if (acc) begin
      st_r   <= st_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ----- hdl/pedec_fifo.sv -----
`timescale 1ns / 1ps
module pedec_fifo
  import pedec_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    push_req,
  input  logic    pop,
  output req_t    head,
  output q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  req_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (lvl_r == LW'(DEPTH));
  assign stat.empty = (lvl_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    lvl_nxt    = lvl_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      lvl_nxt = lvl_r + 1'b1;
    end else if (pop && !push) begin
      lvl_nxt = lvl_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ----- hdl/pedec_back.sv -----
`timescale 1ns / 1ps
module pedec_back
  import pedec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  req_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load, fin;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_comb begin
    load          = !q_stat.empty && (!out_valid_r || out_ready);
    fin           = (idx_r == 2'(head.cnt - 2'd1));
    pop           = load && fin;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = head.bytes[idx_r];
      out_last_nxt  = head.last && fin;
      idx_nxt       = fin ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- hdl/percent_escape_decoder_core.sv -----
`timescale 1ns / 1ps
`include "percent_escape_decoder_core_assert.svh"
// URL percent decoder. Takes one encoded character per cycle and returns the decoded
// bytes one per cycle while out_tready is high: "%XY" with two hex digits becomes one
// byte, '+' becomes a space, a broken escape is passed through raw, and tlast marks the
// final decoded byte. A character that yields two or three bytes (a broken escape or
// the end-of-string flush) holds the output until all are sent; a QUEUE_DEPTH-entry
// request queue between the character classifier and the byte emitter absorbs these
// bursts, and in_tready drops only while that queue is full. Queue and output are
// registered; a '%' or a first hex digit is held until the next character arrives.
module percent_escape_decoder_core
  import pedec_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  q_stat_t q_stat;
  logic    q_push, q_pop, fr_idle;
  req_t    q_req, q_head;

  pedec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_req (q_req),
    .idle     (fr_idle)
  );

  pedec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  pedec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  `PEDEC_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty request queue")
  `PEDEC_ASSERT_NOW(a_push_nonzero, q_push, q_req.cnt != 2'd0, "empty request pushed")
  `PEDEC_ASSERT_NEXT(a_last_clears, in_tvalid && in_tready && in_tlast, fr_idle,
                     "escape still held after final character")
  `PEDEC_ASSERT_NEXT(a_hold_pending, !fr_idle && !in_tvalid, !fr_idle,
                     "held escape lost without input")

endmodule
